### src/longest_prefix_match_router_core_defines.svh
// ----------------------------------------------------------------------------
// longest prefix match router core: assertion macros
// shared property shapes, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef LONGEST_PREFIX_MATCH_ROUTER_CORE_DEFINES_SVH
`define LONGEST_PREFIX_MATCH_ROUTER_CORE_DEFINES_SVH

// same-cycle implication
`define LPMR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LPMR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// condition that must never hold
`define LPMR_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

### src/lpmr_pkg.sv
// ----------------------------------------------------------------------------
// lpmr_pkg
// sizes, codes and beat layouts shared by the route lookup core
// ----------------------------------------------------------------------------
package lpmr_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int ADDR_W = 32;
  localparam int LEN_W  = 6;
  localparam int PORT_W = 4;
  localparam int TTL_W  = 8;

  localparam logic [LEN_W-1:0]  MAX_LEN   = 6'd32;
  localparam logic [ADDR_W-1:0] ALL_ONES  = 32'hffff_ffff;
  localparam logic [TTL_W-1:0]  TTL_ONE   = 8'd1;

  typedef enum logic [0:0] {
    CMD_ADD   = 1'b0,
    CMD_ROUTE = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_ADDED       = 3'd0,
    ST_FORWARDED   = 3'd1,
    ST_NO_ROUTE    = 3'd2,
    ST_TTL_EXPIRED = 3'd3,
    ST_TABLE_FULL  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_SCAN,
    S_LAST,
    S_DONE
  } fsm_t;

  // input beat, last field in the lowest bits
  typedef struct packed {
    logic [4:0]        pad;
    logic [TTL_W-1:0]  hop_limit;
    logic [ADDR_W-1:0] dest_addr;
    logic [PORT_W-1:0] port_index;
    logic [ADDR_W-1:0] gateway_addr;
    logic              has_gateway;
    logic [LEN_W-1:0]  prefix_bits;
    logic [ADDR_W-1:0] prefix;
  } in_data_t;

  typedef struct packed {
    logic [3:0]        pad;
    logic [TTL_W-1:0]  hop_limit_out;
    logic [ADDR_W-1:0] fwd_addr;
    logic [PORT_W-1:0] out_port;
  } out_data_t;

  localparam int IN_TDATA_W  = $bits(in_data_t);
  localparam int OUT_TDATA_W = $bits(out_data_t);

  // one route table entry
  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic              gw_valid;
    logic [ADDR_W-1:0] gw_addr;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] prefix;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // controller to datapath commands
  typedef struct packed {
    logic             load_in;
    logic             add_step;
    logic             table_full;
    logic             wr_en;
    logic             rd_en;
    logic             eval;
    logic             load_out;
    logic [IDX_W-1:0] addr;
  } ctrl_cmd_t;

endpackage

### src/lpmr_ram.sv
// ----------------------------------------------------------------------------
// lpmr_ram
// generic single-clock ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module lpmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### src/lpmr_ctrl.sv
// ----------------------------------------------------------------------------
// lpmr_ctrl
// command sequencer: table fill count, lookup scan and result hand-off
// ----------------------------------------------------------------------------
module lpmr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  lpmr_pkg::cmd_t        in_command,
  input  logic                  out_tready,
  output logic                  in_tready,
  output logic                  out_tvalid,
  output lpmr_pkg::ctrl_cmd_t   cmd
);

  lpmr_pkg::fsm_t state_r, state_nxt;
  logic [lpmr_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [lpmr_pkg::CNT_W-1:0] idx_r, idx_nxt;
  logic eval_r, eval_nxt;
  logic out_valid_r, out_valid_nxt;
  logic full;
  logic out_free;
  logic scan_end;

  assign full     = (count_r == lpmr_pkg::CNT_W'(lpmr_pkg::TABLE_DEPTH));
  assign out_free = !out_valid_r || out_tready;
  assign scan_end = (idx_r == (count_r - lpmr_pkg::CNT_W'(1)));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lpmr_pkg::S_IDLE: begin
        if (in_tvalid) begin
          if (in_command == lpmr_pkg::CMD_ADD) begin
            state_nxt = lpmr_pkg::S_ADD;
          end else if (count_r == '0) begin
            state_nxt = lpmr_pkg::S_DONE;
          end else begin
            state_nxt = lpmr_pkg::S_SCAN;
          end
        end
      end
      lpmr_pkg::S_ADD:  state_nxt = lpmr_pkg::S_DONE;
      lpmr_pkg::S_SCAN: begin
        if (scan_end) begin
          state_nxt = lpmr_pkg::S_LAST;
        end
      end
      lpmr_pkg::S_LAST: state_nxt = lpmr_pkg::S_DONE;
      lpmr_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = lpmr_pkg::S_IDLE;
        end
      end
      default: state_nxt = lpmr_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      lpmr_pkg::S_IDLE: begin
        in_tready   = 1'b1;
        cmd.load_in = in_tvalid;
      end
      lpmr_pkg::S_ADD: begin
        cmd.add_step   = 1'b1;
        cmd.table_full = full;
        cmd.wr_en      = !full;
        cmd.addr       = count_r[lpmr_pkg::IDX_W-1:0];
      end
      lpmr_pkg::S_SCAN: begin
        cmd.rd_en = 1'b1;
        cmd.addr  = idx_r[lpmr_pkg::IDX_W-1:0];
        cmd.eval  = eval_r;
      end
      lpmr_pkg::S_LAST: begin
        cmd.eval = eval_r;
      end
      lpmr_pkg::S_DONE: begin
        cmd.load_out = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // counters and flags
  always_comb begin
    count_nxt = count_r + lpmr_pkg::CNT_W'(cmd.wr_en);
    idx_nxt   = idx_r;
    if (state_r == lpmr_pkg::S_IDLE) begin
      idx_nxt = '0;
    end else if (state_r == lpmr_pkg::S_SCAN) begin
      idx_nxt = idx_r + lpmr_pkg::CNT_W'(1);
    end
    // read data lands in the cycle after the address
    eval_nxt = (state_r == lpmr_pkg::S_SCAN);
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpmr_pkg::S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      eval_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      eval_r      <= eval_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

### src/lpmr_dpath.sv
// ----------------------------------------------------------------------------
// lpmr_dpath
// request registers, route table, prefix compare and result register
// ----------------------------------------------------------------------------
module lpmr_dpath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lpmr_pkg::ctrl_cmd_t  cmd,
  input  lpmr_pkg::cmd_t       in_command,
  input  lpmr_pkg::in_data_t   in_data,
  output lpmr_pkg::out_data_t  out_data,
  output lpmr_pkg::status_t    out_status
);

  lpmr_pkg::cmd_t                  op_r;
  logic [lpmr_pkg::ADDR_W-1:0]     prefix_r;
  logic [lpmr_pkg::LEN_W-1:0]      len_r;
  logic                            gw_valid_r;
  logic [lpmr_pkg::ADDR_W-1:0]     gw_addr_r;
  logic [lpmr_pkg::PORT_W-1:0]     port_r;
  logic [lpmr_pkg::ADDR_W-1:0]     dst_r;
  logic [lpmr_pkg::TTL_W-1:0]      ttl_r;
  logic                            rej_r;

  logic                            found_r;
  logic [lpmr_pkg::LEN_W-1:0]      best_len_r;
  logic [lpmr_pkg::PORT_W-1:0]     best_port_r;
  logic                            best_gw_valid_r;
  logic [lpmr_pkg::ADDR_W-1:0]     best_gw_addr_r;

  lpmr_pkg::out_data_t             out_data_r, res_data;
  lpmr_pkg::status_t               out_status_r, res_status;

  lpmr_pkg::entry_t                wr_entry, rd_entry;
  logic [lpmr_pkg::ENTRY_W-1:0]    rd_word;
  logic [lpmr_pkg::LEN_W-1:0]      sat_len;
  logic [lpmr_pkg::ADDR_W-1:0]     mask;
  logic                            hit;
  logic                            take;

  assign sat_len = (in_data.prefix_bits > lpmr_pkg::MAX_LEN) ? lpmr_pkg::MAX_LEN
                                                            : in_data.prefix_bits;

  always_comb begin
    wr_entry          = '0;
    wr_entry.port     = port_r;
    wr_entry.gw_valid = gw_valid_r;
    wr_entry.gw_addr  = gw_addr_r;
    wr_entry.len      = len_r;
    wr_entry.prefix   = prefix_r;
  end

  lpmr_ram #(
    .WIDTH (lpmr_pkg::ENTRY_W),
    .DEPTH (lpmr_pkg::TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (cmd.addr),
    .wr_data (wr_entry),
    .rd_en   (cmd.rd_en),
    .rd_addr (cmd.addr),
    .rd_data (rd_word)
  );

  assign rd_entry = lpmr_pkg::entry_t'(rd_word);

  // zero-length prefix matches everything
  assign mask = (rd_entry.len == '0) ? '0
              : (lpmr_pkg::ALL_ONES << (lpmr_pkg::MAX_LEN - rd_entry.len));
  assign hit  = (((dst_r ^ rd_entry.prefix) & mask) == '0);
  // >= lets a later route of equal length win
  assign take = cmd.eval && hit && (!found_r || (rd_entry.len >= best_len_r));

  always_comb begin
    res_data   = '0;
    res_status = lpmr_pkg::ST_ADDED;
    if (op_r == lpmr_pkg::CMD_ADD) begin
      res_status = rej_r ? lpmr_pkg::ST_TABLE_FULL : lpmr_pkg::ST_ADDED;
    end else if (!found_r) begin
      res_status = lpmr_pkg::ST_NO_ROUTE;
    end else if (ttl_r <= lpmr_pkg::TTL_ONE) begin
      res_status = lpmr_pkg::ST_TTL_EXPIRED;
    end else begin
      res_status             = lpmr_pkg::ST_FORWARDED;
      res_data.out_port      = best_port_r;
      res_data.fwd_addr      = best_gw_valid_r ? best_gw_addr_r : dst_r;
      res_data.hop_limit_out = ttl_r - lpmr_pkg::TTL_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r       <= in_command;
      prefix_r   <= in_data.prefix;
      len_r      <= sat_len;
      gw_valid_r <= in_data.has_gateway;
      gw_addr_r  <= in_data.has_gateway ? in_data.gateway_addr : '0;
      port_r     <= in_data.port_index;
      dst_r      <= in_data.dest_addr;
      ttl_r      <= in_data.hop_limit;
    end
    if (cmd.add_step) begin
      rej_r <= cmd.table_full;
    end
    if (take) begin
      best_len_r      <= rd_entry.len;
      best_port_r     <= rd_entry.port;
      best_gw_valid_r <= rd_entry.gw_valid;
      best_gw_addr_r  <= rd_entry.gw_addr;
    end
    if (cmd.load_out) begin
      out_data_r   <= res_data;
      out_status_r <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (cmd.load_in) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  assign out_data   = out_data_r;
  assign out_status = out_status_r;

endmodule

### src/longest_prefix_match_router_core.sv
// ----------------------------------------------------------------------------
// longest_prefix_match_router_core
// IPv4 route table with longest prefix lookup. Each input beat is one
// command and gives exactly one result beat. An add writes one table entry
// unless the table is full; a route lookup on an empty table goes straight
// to the result, otherwise it scans every stored route, because the table
// sits in a memory with one read port and the scan reads one stored route
// per cycle. One command is worked on at a time; the result register lets
// the next input beat be taken while the previous result waits for
// out_tready. The table needs no clearing pass after reset.
// ----------------------------------------------------------------------------
`include "longest_prefix_match_router_core_defines.svh"

module longest_prefix_match_router_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // prefix, prefix_bits, has_gateway, gateway_addr, port_index, dest_addr,
  // hop_limit, zero pad
  input  logic [lpmr_pkg::IN_TDATA_W-1:0]  in_tdata,
  // command
  input  logic [0:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_port, forwarding address, hop_limit_out, zero pad
  output logic [lpmr_pkg::OUT_TDATA_W-1:0] out_tdata,
  // status
  output logic [2:0]                       out_tuser
);

  lpmr_pkg::ctrl_cmd_t  ctl_cmd;
  lpmr_pkg::cmd_t       in_command;
  lpmr_pkg::out_data_t  res_data;
  lpmr_pkg::status_t    res_status;

  assign in_command = lpmr_pkg::cmd_t'(in_tuser);

  lpmr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_command (in_command),
    .out_tready (out_tready),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .cmd        (ctl_cmd)
  );

  lpmr_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (ctl_cmd),
    .in_command (in_command),
    .in_data    (lpmr_pkg::in_data_t'(in_tdata)),
    .out_data   (res_data),
    .out_status (res_status)
  );

  assign out_tdata = res_data;
  assign out_tuser = res_status;

  `LPMR_ASSERT_NEVER(a_no_rd_wr, ctl_cmd.wr_en && ctl_cmd.rd_en, "table read and write together")
  `LPMR_ASSERT_NXT(a_one_item, in_tvalid && in_tready, !in_tready, "second beat taken mid-command")
  `LPMR_ASSERT_NXT(a_load_valid, ctl_cmd.load_out, out_tvalid, "loaded result not presented")
  `LPMR_ASSERT_IMP(a_fwd_ttl, out_tvalid && (out_tuser == lpmr_pkg::ST_FORWARDED), res_data.hop_limit_out != '0, "forwarded with zero ttl")

endmodule
